// ===== src/pnrs_pkg.sv =====
// Shared types and fixed widths for the pink noise row-sum block.
package pnrs_pkg;

  localparam int unsigned IN_W   = 16;  // width of the white_sample port
  localparam int unsigned OUT_W  = 16;  // width of the pink_sample port
  localparam int unsigned STEP_W = 16;  // step counter width, wraps

  // Per-transaction control handed from the row sequencer to the sum stage
  typedef struct packed {
    logic start;  // start_new seen: drop running sum
    logic fill;   // row is written during the fill phase, no old value to remove
    logic done;   // this row closes a group, a result follows
  } issue_t;

endpackage

// ===== src/pnrs_row_mem.sv =====
// Row store: single address, read-before-write, registered read data.
module pnrs_row_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // old contents come out the cycle after the write of the new value
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pnrs_ctrl.sv =====
// Row sequencer: fill phase, step counter, group end and next row address.
module pnrs_ctrl #(
  parameter int unsigned ROW_COUNT = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         start_new_i,
  output logic [$clog2(ROW_COUNT)-1:0] row_o,
  output pnrs_pkg::issue_t             issue_o
);

  localparam int unsigned AW = $clog2(ROW_COUNT);

  // trailing-zero index of n, limited to the last row
  function automatic logic [AW-1:0] last_row_for(input logic [pnrs_pkg::STEP_W-1:0] n);
    logic [AW-1:0] res;
    logic          found;
    res   = AW'(ROW_COUNT - 1);
    found = 1'b0;
    for (int i = 0; i < int'(pnrs_pkg::STEP_W); i++) begin
      if (!found && (i < int'(ROW_COUNT)) && n[i]) begin
        res   = AW'(i);
        found = 1'b1;
      end
    end
    return res;
  endfunction

  logic                        filling_q, filling_d;
  logic [AW-1:0]               ptr_q, ptr_d;
  logic [AW-1:0]               last_q, last_d;
  logic [pnrs_pkg::STEP_W-1:0] step_q, step_d;

  logic                        fill;
  logic [AW-1:0]               ptr, last;
  logic [pnrs_pkg::STEP_W-1:0] step, step_inc;
  logic                        done;

  // a start request rewinds everything before this row is placed
  always_comb begin
    fill     = start_new_i ? 1'b1 : filling_q;
    ptr      = start_new_i ? '0   : ptr_q;
    last     = start_new_i ? '0   : last_q;
    step     = start_new_i ? '0   : step_q;
    step_inc = step + pnrs_pkg::STEP_W'(1);
    done     = fill ? (ptr == AW'(ROW_COUNT - 1)) : (ptr >= last);
  end

  always_comb begin
    filling_d = filling_q;
    ptr_d     = ptr_q;
    last_d    = last_q;
    step_d    = step_q;
    if (accept_i) begin
      if (done) begin
        filling_d = 1'b0;
        ptr_d     = '0;
        step_d    = step_inc;
        last_d    = last_row_for(step_inc);
      end else begin
        filling_d = fill;
        ptr_d     = ptr + AW'(1);
        step_d    = step;
        last_d    = last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filling_q <= 1'b1;
      ptr_q     <= '0;
      last_q    <= '0;
      step_q    <= '0;
    end else begin
      filling_q <= filling_d;
      ptr_q     <= ptr_d;
      last_q    <= last_d;
      step_q    <= step_d;
    end
  end

  assign row_o         = ptr;
  assign issue_o.start = start_new_i;
  assign issue_o.fill  = fill;
  assign issue_o.done  = done;

endmodule

// ===== src/pnrs_mean.sv =====
// Floor mean: offset sum divided by ROW_COUNT via reciprocal multiply and one correction.
module pnrs_mean #(
  parameter int unsigned ROW_COUNT = 16,
  parameter int unsigned SAMPLE_W  = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  logic [SAMPLE_W+$clog2(ROW_COUNT)-1:0]     sum_i,    // sum plus offset, unsigned
  output logic                                      stall_o,
  output logic                                      valid_o,
  input  logic                                      stall_i,
  output logic signed [pnrs_pkg::OUT_W-1:0]         mean_o
);

  localparam int unsigned LR = $clog2(ROW_COUNT);
  localparam int unsigned UW = SAMPLE_W + LR;
  localparam int unsigned MW = UW + 1;
  localparam int unsigned SH = UW + LR;
  localparam int unsigned PW = UW + MW;
  localparam longint unsigned RECIP = (64'd1 << SH) / ROW_COUNT;
  localparam logic [MW-1:0] RECIP_M = RECIP[MW-1:0];

  logic              v2_q, v3_q;
  logic              adv2, adv3;
  logic [UW-1:0]     u2_q;
  logic [PW-1:0]     prod_q;
  logic [SAMPLE_W-1:0] q_est, q_fix, q_signed;
  logic [UW:0]       q_times_r, rem;
  logic signed [pnrs_pkg::OUT_W-1:0] mean_q, mean_d;

  assign adv3    = !v3_q || !stall_i;
  assign adv2    = !v2_q || adv3;
  assign stall_o = !adv2;

  // estimate is exact or one low
  always_comb begin
    q_est     = prod_q[SH +: SAMPLE_W];
    q_times_r = (UW + 1)'(q_est) * (UW + 1)'(ROW_COUNT);
    rem       = {1'b0, u2_q} - q_times_r;
    q_fix     = (rem >= (UW + 1)'(ROW_COUNT)) ? q_est + SAMPLE_W'(1) : q_est;
    // remove the offset of half range: flip the top bit
    q_signed  = q_fix ^ (SAMPLE_W'(1) << (SAMPLE_W - 1));
    mean_d    = pnrs_pkg::OUT_W'(signed'(q_signed));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv2) v2_q <= valid_i;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && valid_i) begin
      u2_q   <= sum_i;
      prod_q <= PW'(sum_i) * PW'(RECIP_M);
    end
    if (adv3 && v2_q) begin
      mean_q <= mean_d;
    end
  end

  assign valid_o = v3_q;
  assign mean_o  = mean_q;

endmodule

// ===== src/pink_noise_row_sum.sv =====
// Top level: Voss-McCartney pink noise with row memory and running row sum.
//
// Pink noise generator of the Voss-McCartney kind. Each accepted transaction
// carries one white sample that replaces the next row of a ROW_COUNT-row
// store, and a running sum of all rows is corrected by the difference. After
// reset or a start_new transaction the first ROW_COUNT samples fill all rows;
// after that each group refreshes rows 0 up to the trailing-zero index of the
// step counter (all rows when its low bits are zero). The transaction that
// closes a group produces one pink_sample, floor(sum / ROW_COUNT); other
// transactions produce nothing. One sample is taken every clock cycle while
// the input is not stalled: each sample does a single read-before-write on
// the row memory, whose old value reaches the sum stage the next cycle, so
// no interlock is needed. A result goes through the sum stage, reciprocal
// multiply and correction into the output register. Backpressure on the
// output only stalls the input once the pipeline is full. Only the low
// min(SAMPLE_BITS,16) bits of white_sample are used, taken as signed.
module pink_noise_row_sum #(
  parameter int unsigned ROW_COUNT   = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [pnrs_pkg::IN_W-1:0]   white_sample_i,
  input  logic                               start_new_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pnrs_pkg::OUT_W-1:0]  pink_sample_o
);

  localparam int unsigned SW = (SAMPLE_BITS < pnrs_pkg::IN_W) ? SAMPLE_BITS : pnrs_pkg::IN_W;
  localparam int unsigned LR = $clog2(ROW_COUNT);
  localparam int unsigned AW = LR;
  localparam int unsigned UW = SW + LR;
  localparam int unsigned TW = UW + 1;
  // offset that makes any possible sum non-negative
  localparam logic [TW-1:0] SUM_OFS = TW'(ROW_COUNT) << (SW - 1);

  logic                 accept;
  logic                 mean_stall;
  logic                 adv1;
  logic [AW-1:0]        row;
  pnrs_pkg::issue_t     issue;
  logic [SW-1:0]        sample;
  logic [SW-1:0]        old_row;

  // sum stage
  logic                 v1_q;
  pnrs_pkg::issue_t     issue1_q;
  logic [SW-1:0]        s1_q;
  logic signed [TW-1:0] total_q, total_d, base;
  logic [TW-1:0]        shifted;

  assign sample     = white_sample_i[SW-1:0];
  assign adv1       = !v1_q || !mean_stall;
  assign in_stall_o = !adv1;
  assign accept     = in_valid_i && adv1;

  pnrs_ctrl #(
    .ROW_COUNT (ROW_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .start_new_i (start_new_i),
    .row_o       (row),
    .issue_o     (issue)
  );

  pnrs_row_mem #(
    .DEPTH (ROW_COUNT),
    .WIDTH (SW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (accept),
    .addr_i  (row),
    .wdata_i (sample),
    .rdata_o (old_row)
  );

  // running sum: drop the old row (not during fill) and add the new one
  always_comb begin
    base    = issue1_q.start ? '0 : total_q;
    total_d = base + TW'(signed'(s1_q));
    if (!issue1_q.fill) begin
      total_d = total_d - TW'(signed'(old_row));
    end
    shifted = total_d + SUM_OFS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      total_q <= '0;
    end else begin
      if (adv1) v1_q <= accept;
      if (v1_q && adv1) total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      issue1_q <= issue;
      s1_q     <= sample;
    end
  end

  pnrs_mean #(
    .ROW_COUNT (ROW_COUNT),
    .SAMPLE_W  (SW)
  ) u_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q && issue1_q.done),
    .sum_i   (shifted[UW-1:0]),
    .stall_o (mean_stall),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .mean_o  (pink_sample_o)
  );

endmodule

// ===== dv/tb_pink_noise_row_sum.sv =====
// Self-checking testbench for the Voss-McCartney pink noise row-sum block.
module tb_pink_noise_row_sum;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_COUNT   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int SMP_W       = pnrs_pkg::IN_W;
  localparam int STEP_W      = pnrs_pkg::STEP_W;

  // Run caps: hang guard, output drain after the last transaction, hold-off length
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned END_SLACK   = 8;  // result pipeline drain plus margin
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PRINT_CAP   = 30;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    start;
  } white_item_t;

  // Per-sequence flavor of white samples
  typedef enum int {
    SMP_UNIFORM,
    SMP_EDGES,
    SMP_TINY,
    SMP_ALL_MAX,
    SMP_ALL_MIN
  } sample_style_e;

  // Receiver back-pressure pattern
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT ports (every input known from time zero)
  // ---------------------------------------------------------------------------
  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic signed [SMP_W-1:0]       white_sample_i = '0;
  logic                          start_new_i    = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic signed [pnrs_pkg::OUT_W-1:0] pink_sample_o;

  pink_noise_row_sum #(
    .ROW_COUNT  (ROW_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .white_sample_i(white_sample_i),
    .start_new_i   (start_new_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pink_sample_o (pink_sample_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  white_item_t                       white_q[$];       // transactions not yet offered
  logic signed [pnrs_pkg::OUT_W-1:0] pink_expect_q[$]; // predicted pink samples, oldest first

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_ask    = 0;  // bumped by stimulus to request a long output hold-off
  int unsigned hold_served = 0;
  logic        in_taken    = 1'b0;  // input transaction accepted at the last rising edge

  // ---------------------------------------------------------------------------
  // Row-sum predictor: own copy of the generator state
  // ---------------------------------------------------------------------------
  logic signed [SMP_W-1:0] row_mem [ROW_COUNT];
  int                      row_sum    = 0;   // exact signed sum of all rows
  logic [STEP_W-1:0]       step_n     = '0;  // Voss step counter, wraps
  int                      row_ptr    = 0;   // next row to refresh
  int                      group_end  = 0;   // last row of the current group
  bit                      filling    = 1'b1;

  // Applies one white sample; returns whether it closed a group, and the mean.
  task automatic advance_rows(input logic signed [SMP_W-1:0] smp, input logic start,
                              output bit closed, output logic signed [15:0] pink);
    int p;
    int q;
    int k;
    closed = 1'b0;
    pink   = '0;
    // start_new drops any partial group and refills from row 0
    if (start) begin
      filling   = 1'b1;
      row_sum   = 0;
      step_n    = '0;
      row_ptr   = 0;
      group_end = 0;
    end
    p = (row_ptr >= ROW_COUNT) ? 0 : row_ptr;
    if (filling) begin
      row_mem[p] = smp;
      row_sum    = row_sum + smp;
      closed     = (p == ROW_COUNT - 1);
    end else begin
      row_sum    = row_sum - row_mem[p] + smp;
      row_mem[p] = smp;
      closed     = (p >= group_end);
    end
    if (!closed) begin
      row_ptr = p + 1;
    end else begin
      // floor division: C-style truncation, then pull negatives down
      q = row_sum / ROW_COUNT;
      if ((row_sum % ROW_COUNT) != 0 && row_sum < 0) q = q - 1;
      pink    = q[15:0];
      filling = 1'b0;
      step_n  = step_n + 1'b1;
      // next group ends at the trailing-zero index, all rows on a zero counter
      k = 0;
      while (k < ROW_COUNT && k < STEP_W && !step_n[k]) k++;
      group_end = (k >= ROW_COUNT) ? ROW_COUNT - 1 : k;
      row_ptr   = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("mismatch %0d at cycle %0d: %s got %0d want %0d",
               err_count, cycle_count, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input transactions, checks output transactions
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor_p
    bit                                closed;
    logic signed [pnrs_pkg::OUT_W-1:0] pink;
    logic signed [pnrs_pkg::OUT_W-1:0] want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        advance_rows(white_sample_i, start_new_i, closed, pink);
        if (closed) pink_expect_q = {pink_expect_q, pink};
      end
      if (out_valid_o && !out_stall_i) begin
        if (pink_expect_q.size() == 0) begin
          report_mismatch("unexpected pink_sample", pink_sample_o, 0);
        end else begin
          want = pink_expect_q.pop_front();
          if (pink_sample_o !== want) report_mismatch("pink_sample", pink_sample_o, want);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued transactions in bursts with random gaps. Valid
  // stays up and the payload frozen until the transaction is accepted.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : driver_p
    white_item_t item;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0 || white_q.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        item = white_q.pop_front();
        in_valid_i     <= 1'b1;
        white_sample_i <= item.sample;
        start_new_i    <= item.start;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          // a quarter of the bursts run back to back
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switches every so often; a requested hold-off
  // keeps stall up for HOLD_CYCLES so the pipeline backs up into the input.
  // ---------------------------------------------------------------------------
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;

  always @(negedge clk_i) begin : receiver_p
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_ask) begin
      hold_served = hold_ask;
      hold_left   = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:   out_stall_i <= 1'b0;
        STALL_LIGHT:  out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall_i <= ($urandom_range(0, 3) != 0);
        default:      out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic signed [SMP_W-1:0] smp, input logic start);
    white_item_t item;
    item.sample = smp;
    item.start  = start;
    white_q = {white_q, item};
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample(input sample_style_e style);
    logic [SMP_W-1:0] v;
    case (style)
      SMP_ALL_MAX: v = 16'h7fff;
      SMP_ALL_MIN: v = 16'h8000;
      SMP_EDGES: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h7fff;
          1:       v = 16'h8000;
          2:       v = 16'h0000;
          default: v = 16'hffff;
        endcase
      end
      SMP_TINY:  v = SMP_W'($urandom_range(0, 16)) - SMP_W'(8);
      default:   v = SMP_W'($urandom);
    endcase
    return $signed(v);
  endfunction

  // Mostly well-formed runs (fill then many groups) opened by start_new;
  // some runs break off mid-fill, and a rare stray start lands mid-group.
  task automatic push_random_runs(input int unsigned n_items);
    int unsigned   pushed;
    int unsigned   run_len;
    int unsigned   r;
    sample_style_e style;
    pushed = 0;
    while (pushed < n_items) begin
      r = $urandom_range(0, 9);
      if (r <= 5)      style = SMP_UNIFORM;
      else if (r == 6) style = SMP_EDGES;
      else if (r == 7) style = SMP_TINY;
      else if (r == 8) style = SMP_ALL_MAX;
      else             style = SMP_ALL_MIN;
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, ROW_COUNT - 1)
                                           : $urandom_range(ROW_COUNT, 150);
      for (int unsigned j = 0; j < run_len; j++) begin
        push_item(pick_sample(style), (j == 0) || ($urandom_range(0, 199) == 0));
      end
      pushed += run_len;
    end
  endtask

  // Sender side quiet: all queued transactions accepted and all results in.
  task automatic wait_drained();
    while (white_q.size() != 0 || in_valid_i || pink_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: full-scale fill, then early groups with negative full scale
    push_item(16'sh7fff, 1'b1);
    repeat (ROW_COUNT - 1) push_item(16'sh7fff, 1'b0);
    push_item(16'sh8000, 1'b0);                       // n=1: row 0 only
    repeat (2) push_item(16'sh8000, 1'b0);            // n=2: rows 0..1
    push_item(16'sh8000, 1'b0);                       // n=3: row 0
    push_item(16'sh8000, 1'b0);                       // n=4 group begins...
    push_item(16'sh8000, 1'b1);                       // ...and a start drops it
    push_item(-16'sd1, 1'b0);
    push_item(16'sh0000, 1'b0);
    push_item(16'sh0001, 1'b0);
    wait_drained();

    // Random runs; a long output hold-off while the sender keeps offering
    push_random_runs(700);
    hold_ask++;
    wait_drained();

    push_random_runs(700);
    wait_drained();

    // Let any stray result surface before the verdict
    repeat (END_SLACK) @(posedge clk_i);
    if (err_count == 0 && pink_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
